### src/crc16_stuffed_frame_encoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-16 stuffed frame encoder
// Shorthand for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef CRC16_STUFFED_FRAME_ENCODER_MACROS_SVH
`define CRC16_STUFFED_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define CRCSFE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crcsfe: same-cycle check failed");

// next-cycle implication
`define CRCSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crcsfe: next-cycle check failed");

`endif

### src/crcsfe_pkg.sv
// ----------------------------------------------------------------------------
// crcsfe_pkg
// Shared types, register codes and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcsfe_pkg;

   // default depth of the job queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // configuration register indexes
   localparam logic [1:0] CSR_START_MARKER = 2'd0;
   localparam logic [1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [1:0] CSR_STOP_MARKER  = 2'd2;

   // one classified payload byte, as handed from front to back
   typedef struct packed {
      logic        has_start;   // frame opens with this byte
      logic [7:0]  data;
      logic        data_dbl;    // byte equals the start or end marker, send twice
      logic        last;        // trailer follows
      logic [15:0] crc;         // CRC after this byte
      logic        crc_lo_dbl;
      logic        crc_hi_dbl;
   } job_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // back sequencer phases
   typedef enum logic [3:0] {
      PH_START,
      PH_DATA,
      PH_DATA2,
      PH_CRCL,
      PH_CRCL2,
      PH_CRCH,
      PH_CRCH2,
      PH_END,
      PH_STOP
   } phase_type;

   // CRC-16, MSB first, one byte
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### src/crcsfe_front.sv
// ----------------------------------------------------------------------------
// crcsfe_front
// Accepts payload words, runs the CRC and classifies each byte into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module crcsfe_front
   import crcsfe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [7:0]       req_tdata,    // [7:0] data_byte
   input  wire logic             req_tlast,    // frame_last
   input  wire logic [7:0]       start_marker,
   input  wire logic [7:0]       end_marker,
   input  wire queue_status_type q_status,
   output      logic             push,
   output      job_type          push_job
);

   logic        inside_ff, inside_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_new;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   // CRC restarts at zero on the first byte of a frame
   assign crc_new = crc16_update(inside_ff ? crc_ff : 16'h0000, req_tdata);

   // classify the byte
   always_comb begin
      push_job.has_start  = !inside_ff;
      push_job.data       = req_tdata;
      push_job.data_dbl   = (req_tdata == start_marker) || (req_tdata == end_marker);
      push_job.last       = req_tlast;
      push_job.crc        = crc_new;
      push_job.crc_lo_dbl = (crc_new[7:0] == start_marker) ||
                            (crc_new[7:0] == end_marker);
      push_job.crc_hi_dbl = (crc_new[15:8] == start_marker) ||
                            (crc_new[15:8] == end_marker);
   end

   // frame state
   always_comb begin
      inside_in = inside_ff;
      crc_in    = crc_ff;
      if (push) begin
         inside_in = !req_tlast;
         crc_in    = req_tlast ? 16'h0000 : crc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         crc_ff    <= 16'h0000;
      end else begin
         inside_ff <= inside_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

`default_nettype wire

### src/crcsfe_queue.sv
// ----------------------------------------------------------------------------
// crcsfe_queue
// Short job queue that decouples the front from the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module crcsfe_queue
   import crcsfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire job_type   push_job,
   input  wire logic      pop,
   output      job_type   head,
   output queue_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### src/crcsfe_back.sv
// ----------------------------------------------------------------------------
// crcsfe_back
// Sequencer that expands each job into stuffed output words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crc16_stuffed_frame_encoder_macros.svh"

module crcsfe_back
   import crcsfe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       start_marker,
   input  wire logic [7:0]       end_marker,
   input  wire logic [7:0]       stop_marker,
   input  wire job_type          head,
   input  wire queue_status_type q_status,
   output      logic             pop,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [7:0]       rsp_tdata,    // [7:0] out_byte
   output      logic             rsp_tlast,    // run_last
   output      logic             rsp_tuser     // frame_done
);

   logic       active_ff, active_in;
   phase_type  phase_ff, phase_in;
   phase_type  cur_phase, next_phase;
   logic       emit;
   logic       final_c;
   logic [7:0] byte_c;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;

   // phase of the word to send for the head job
   always_comb begin
      if (active_ff) begin
         cur_phase = phase_ff;
      end else begin
         cur_phase = head.has_start ? PH_START : PH_DATA;
      end
   end

   // next state
   always_comb begin
      case (cur_phase)
         PH_START: next_phase = PH_DATA;
         PH_DATA:  next_phase = head.data_dbl ? PH_DATA2 : PH_CRCL;
         PH_DATA2: next_phase = PH_CRCL;
         PH_CRCL:  next_phase = head.crc_lo_dbl ? PH_CRCL2 : PH_CRCH;
         PH_CRCL2: next_phase = PH_CRCH;
         PH_CRCH:  next_phase = head.crc_hi_dbl ? PH_CRCH2 : PH_END;
         PH_CRCH2: next_phase = PH_END;
         PH_END:   next_phase = PH_STOP;
         PH_STOP:  next_phase = PH_DATA;
         default:  next_phase = PH_DATA;
      endcase
   end

   // outputs: byte to send and whether it ends this job
   always_comb begin
      case (cur_phase)
         PH_START: begin
            byte_c  = start_marker;
            final_c = 1'b0;
         end
         PH_DATA: begin
            byte_c  = head.data;
            final_c = !head.last && !head.data_dbl;
         end
         PH_DATA2: begin
            byte_c  = head.data;
            final_c = !head.last;
         end
         PH_CRCL, PH_CRCL2: begin
            byte_c  = head.crc[7:0];
            final_c = 1'b0;
         end
         PH_CRCH, PH_CRCH2: begin
            byte_c  = head.crc[15:8];
            final_c = 1'b0;
         end
         PH_END: begin
            byte_c  = end_marker;
            final_c = 1'b0;
         end
         PH_STOP: begin
            byte_c  = stop_marker;
            final_c = 1'b1;
         end
         default: begin
            byte_c  = head.data;
            final_c = 1'b1;
         end
      endcase
   end

   // one word per cycle whenever a job is queued and the output register can take it
   assign emit = !q_status.empty && (!valid_ff || rsp_tready);
   assign pop  = emit && final_c;

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      valid_in  = valid_ff && !rsp_tready;
      data_in   = data_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      if (emit) begin
         active_in = !final_c;
         phase_in  = next_phase;
         valid_in  = 1'b1;
         data_in   = byte_c;
         last_in   = final_c;
         done_in   = (cur_phase == PH_STOP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= PH_DATA;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         valid_ff  <= valid_in;
      end
   end

   // output payload, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

   // checks
   `CRCSFE_ASSERT_SAME(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `CRCSFE_ASSERT_SAME(a_active_has_job, clock, reset, active_ff, !q_status.empty)
   `CRCSFE_ASSERT_NEXT(a_stop_ends_job, clock, reset, emit && (cur_phase == PH_STOP),
                       !active_ff)

endmodule

`default_nettype wire

### src/crc16_stuffed_frame_encoder.sv
// Path: an accepted payload word is written into a QUEUE_DEPTH job queue that
// lets input run on; its first output word is then registered onto rsp_tdata.
// Output: one word per cycle from the back sequencer while a job is queued
// and the output register is free; a payload word yields one word, two if
// doubled, more with start and trailer (up to 9 for a single-byte frame).
// Reset: synchronous, active high; clears markers, CRC, frame state and queue.
// ----------------------------------------------------------------------------
// crc16_stuffed_frame_encoder
// Byte-stuffed framing with a CRC-16 trailer and start, end and stop markers.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_stuffed_frame_encoder
   import crcsfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // payload words
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] data_byte
   input  wire logic       req_tlast,    // frame_last
   // framed stream
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,    // [7:0] out_byte
   output      logic       rsp_tlast,    // run_last
   output      logic       rsp_tuser,    // [0] frame_done
   // register writes
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   logic [7:0] start_ff, start_in;
   logic [7:0] end_ff, end_in;
   logic [7:0] stop_ff, stop_in;

   logic             push, pop;
   job_type          push_job, head;
   queue_status_type q_status;

   // marker registers
   assign csr_ready = 1'b1;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      stop_in  = stop_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_MARKER: start_in = csr_wdata;
            CSR_END_MARKER:   end_in   = csr_wdata;
            CSR_STOP_MARKER:  stop_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 8'h00;
         end_ff   <= 8'h00;
         stop_ff  <= 8'h00;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
         stop_ff  <= stop_in;
      end
   end

   crcsfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .start_marker (start_ff),
      .end_marker   (end_ff),
      .q_status     (q_status),
      .push         (push),
      .push_job     (push_job)
   );

   crcsfe_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   crcsfe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .start_marker (start_ff),
      .end_marker   (end_ff),
      .stop_marker  (stop_ff),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

`default_nettype wire
